@@ rtl/core/terminal_key_sequence_decoder_macros.svh @@
// Assertion macros shared by the terminal key sequence decoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define TKSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tksd assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is active.
`define TKSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tksd assertion failed (next cycle)");

`endif

@@ rtl/core/tkd_pkg.sv @@
// Shared types, codes and decode helpers for the terminal key sequence decoder.
// Depends on nothing; imported by every module of the block.
package tkd_pkg;

    // Parser state codes.
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ESC  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CSI  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIG  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SKIP = 3'd4;

    // Key codes.
    localparam logic [3:0] KEY_CHAR  = 4'd0;
    localparam logic [3:0] KEY_UP    = 4'd1;
    localparam logic [3:0] KEY_DOWN  = 4'd2;
    localparam logic [3:0] KEY_RIGHT = 4'd3;
    localparam logic [3:0] KEY_LEFT  = 4'd4;
    localparam logic [3:0] KEY_HOME  = 4'd5;
    localparam logic [3:0] KEY_END   = 4'd6;
    localparam logic [3:0] KEY_PGUP  = 4'd7;
    localparam logic [3:0] KEY_PGDN  = 4'd8;
    localparam logic [3:0] KEY_ESC   = 4'd9;
    localparam logic [3:0] KEY_ENTER = 4'd10;
    localparam logic [3:0] KEY_BKSP  = 4'd11;
    localparam logic [3:0] KEY_TAB   = 4'd12;

    // Byte values the parser looks for.
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_LBRK  = 8'h5B;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;
    localparam logic [7:0] BYTE_FIVE  = 8'h35;
    localparam logic [7:0] BYTE_SIX   = 8'h36;
    localparam logic [7:0] BYTE_UP    = 8'h41;
    localparam logic [7:0] BYTE_DOWN  = 8'h42;
    localparam logic [7:0] BYTE_RIGHT = 8'h43;
    localparam logic [7:0] BYTE_LEFT  = 8'h44;
    localparam logic [7:0] BYTE_END   = 8'h46;
    localparam logic [7:0] BYTE_HOME  = 8'h48;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] FINAL_LO   = 8'h40;
    localparam logic [7:0] FINAL_HI   = 8'h7E;

    // Command queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One key event.
    typedef struct packed {
        logic [3:0] key;
        logic [7:0] chr;
    } event_t;

    // One queued command: the final event of a byte, preceded by an Escape when dual is set.
    typedef struct packed {
        logic   dual;
        event_t ev;
    } cmd_t;

    // Queue status seen by the front end and the checks.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // True for a CSI final byte.
    function automatic logic is_final(input logic [7:0] b);
        return (b >= FINAL_LO) && (b <= FINAL_HI);
    endfunction

    // Event for a non-Escape byte seen from the idle state.
    function automatic event_t decode_idle(input logic [7:0] b);
        event_t ev;
        ev.chr = 8'h00;
        case (b) inside
            BYTE_CR, BYTE_LF:  ev.key = KEY_ENTER;
            BYTE_DEL, BYTE_BS: ev.key = KEY_BKSP;
            BYTE_TAB:          ev.key = KEY_TAB;
            default:
            begin
                ev.key = KEY_CHAR;
                ev.chr = b;
            end
        endcase
        return ev;
    endfunction

endpackage

@@ rtl/core/tkd_front.sv @@
// Front end: accepts input bytes, runs the escape sequence parser and queues commands.
// Depends on tkd_pkg.
module tkd_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                in_byte,
    input  logic                      end_of_buffer,
    input  tkd_pkg::q_status_t        q_status,
    output logic                      push,
    output tkd_pkg::cmd_t             push_cmd,
    output logic [tkd_pkg::MODE_W-1:0] mode
);
    import tkd_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              pdp_reg;
    logic              pdp_next;
    logic              lead_esc;
    logic              tail_esc;
    logic              main_v;
    event_t            main_ev;
    event_t            idle_ev;
    logic              accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign idle_ev  = decode_idle(in_byte);
    assign mode     = mode_reg;

    // Parser next state and the events this byte causes.
    always_comb
    begin
        mode_next = mode_reg;
        pdp_next  = pdp_reg;
        lead_esc  = 1'b0;
        main_v    = 1'b0;
        main_ev   = '0;
        unique case (mode_reg)
            MODE_ESC:
            begin
                if (in_byte == BYTE_LBRK)
                begin
                    mode_next = MODE_CSI;
                end
                else
                begin
                    lead_esc = 1'b1;
                    if (in_byte == BYTE_ESC)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                        main_v    = 1'b1;
                        main_ev   = idle_ev;
                    end
                end
            end
            MODE_CSI:
            begin
                mode_next = MODE_IDLE;
                case (in_byte) inside
                    BYTE_UP:    begin main_v = 1'b1; main_ev.key = KEY_UP;    end
                    BYTE_DOWN:  begin main_v = 1'b1; main_ev.key = KEY_DOWN;  end
                    BYTE_RIGHT: begin main_v = 1'b1; main_ev.key = KEY_RIGHT; end
                    BYTE_LEFT:  begin main_v = 1'b1; main_ev.key = KEY_LEFT;  end
                    BYTE_HOME:  begin main_v = 1'b1; main_ev.key = KEY_HOME;  end
                    BYTE_END:   begin main_v = 1'b1; main_ev.key = KEY_END;   end
                    BYTE_FIVE, BYTE_SIX:
                    begin
                        pdp_next  = (in_byte == BYTE_SIX);
                        mode_next = MODE_DIG;
                    end
                    default:
                    begin
                        if (!is_final(in_byte))
                        begin
                            mode_next = MODE_SKIP;
                        end
                    end
                endcase
            end
            MODE_DIG:
            begin
                if (in_byte == BYTE_TILDE)
                begin
                    main_v      = 1'b1;
                    main_ev.key = pdp_reg ? KEY_PGDN : KEY_PGUP;
                    mode_next   = MODE_IDLE;
                end
                else
                begin
                    mode_next = is_final(in_byte) ? MODE_IDLE : MODE_SKIP;
                end
                pdp_next = 1'b0;
            end
            MODE_SKIP:
            begin
                if (is_final(in_byte))
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                if (in_byte == BYTE_ESC)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    main_v    = 1'b1;
                    main_ev   = idle_ev;
                end
            end
        endcase
        // A buffer end flushes a pending Escape and drops any partial sequence.
        tail_esc = end_of_buffer && (mode_next == MODE_ESC);
        if (end_of_buffer)
        begin
            mode_next = MODE_IDLE;
            pdp_next  = 1'b0;
        end
    end

    // Command for the queue; the first of two events is always Escape.
    always_comb
    begin
        push_cmd.dual = lead_esc && (main_v || tail_esc);
        if (tail_esc || !main_v)
        begin
            push_cmd.ev.key = KEY_ESC;
            push_cmd.ev.chr = 8'h00;
        end
        else
        begin
            push_cmd.ev = main_ev;
        end
        push = accept && (lead_esc || main_v || tail_esc);
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pdp_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pdp_reg  <= pdp_next;
        end
    end

endmodule

@@ rtl/core/tkd_queue.sv @@
// Short command queue that decouples the parser from the event output stage.
// Depends on tkd_pkg.
module tkd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tkd_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output tkd_pkg::cmd_t      head,
    output tkd_pkg::q_status_t status
);
    import tkd_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    // Storage is written in place and needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/tkd_back.sv @@
// Back end: expands queued commands into key events on a registered output stage.
// Depends on tkd_pkg.
module tkd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tkd_pkg::cmd_t      head,
    input  tkd_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output tkd_pkg::event_t    out_ev,
    output logic               out_last
);
    import tkd_pkg::*;

    logic   out_valid_reg;
    event_t out_ev_reg;
    logic   out_last_reg;
    logic   sec_pending_reg;
    event_t sec_ev_reg;
    logic   load;

    assign out_valid = out_valid_reg;
    assign out_ev    = out_ev_reg;
    assign out_last  = out_last_reg;
    assign load      = !out_valid_reg || out_ready;
    assign pop       = load && !sec_pending_reg && !q_status.empty;

    // Output stage control: second half of a dual command goes before the next pop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            sec_pending_reg <= 1'b0;
        end
        else if (load)
        begin
            if (sec_pending_reg)
            begin
                out_valid_reg   <= 1'b1;
                sec_pending_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg   <= !q_status.empty;
                sec_pending_reg <= !q_status.empty && head.dual;
            end
        end
    end

    // Output payload and the held second event.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (sec_pending_reg)
            begin
                out_ev_reg   <= sec_ev_reg;
                out_last_reg <= 1'b1;
            end
            else if (head.dual)
            begin
                out_ev_reg.key <= KEY_ESC;
                out_ev_reg.chr <= 8'h00;
                out_last_reg   <= 1'b0;
                sec_ev_reg     <= head.ev;
            end
            else
            begin
                out_ev_reg   <= head.ev;
                out_last_reg <= 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/terminal_key_sequence_decoder.sv @@
// Terminal key sequence decoder: turns terminal input bytes into key events. A byte is
// accepted every cycle while the four-entry command queue between parser and output
// stage has room; results leave from a registered output stage one per cycle while the
// receiver is ready. A byte yields zero, one or two events; a byte that yields two (a
// lone Escape followed by a byte other than [ or Escape, or two Escapes at a buffer
// end) holds the output stage for both events before the next command is popped. The
// first event of a byte is written into the queue when the byte is accepted and is
// then registered into the output stage, which the receiver can stall. No clearing
// pass after reset. Depends on tkd_pkg, tkd_front, tkd_queue, tkd_back and the macros.
`include "terminal_key_sequence_decoder_macros.svh"

module terminal_key_sequence_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] key_code, [11:4] char_value, [15:12] zero
    output logic        m_tlast    // last_of_run
);
    import tkd_pkg::*;

    logic              push;
    cmd_t              push_cmd;
    cmd_t              head;
    q_status_t         q_status;
    logic              pop;
    logic [MODE_W-1:0] mode;
    event_t            out_ev;

    tkd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .end_of_buffer (s_tlast),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd),
        .mode          (mode)
    );

    tkd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    tkd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ev    (out_ev),
        .out_last  (m_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {4'b0000, out_ev.chr, out_ev.key};

    // The parser never pushes into a full queue and the output never pops an empty one.
    `TKSD_ASSERT_IMPL(a_push_not_full, clk, rst_n, push, !q_status.full)
    `TKSD_ASSERT_IMPL(a_pop_not_empty, clk, rst_n, pop, !q_status.empty)
    // A buffer end always leaves the parser idle.
    `TKSD_ASSERT_NEXT(a_eob_idle, clk, rst_n, s_tvalid && s_tready && s_tlast, mode == MODE_IDLE)

endmodule

@@ test/terminal_key_sequence_decoder_tb.sv @@
// Self-checking testbench for the terminal key sequence decoder: directed byte
// sequences, then random well-formed and broken escape traffic, with and without random idling.
// Depends on tkd_pkg and the terminal_key_sequence_decoder RTL.
`timescale 1ns / 100ps

module terminal_key_sequence_decoder_tb;

    import tkd_pkg::*;

    // One expected key event as it should leave the master side.
    typedef struct packed {
        logic [3:0] key;
        logic [7:0] chr;
        logic       last;
    } key_event_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_tlast  = 1'b0;    // end_of_buffer
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [3:0] key_code, [11:4] char_value, [15:12] zero
    logic        m_tlast;            // last_of_run

    // Idling percentages for the sending and receiving sides.
    int src_idle_pct   = 29;
    int sink_stall_pct = 45;

    int bytes_sent = 0;
    int fail_count = 0;

    // Key events still to come, oldest first, and the events of the current byte.
    key_event_t expected_keys[$];
    key_event_t byte_events[$];

    // Parser state as the checker tracks it.
    logic [MODE_W-1:0] pred_mode = MODE_IDLE;
    logic              pred_pgdn = 1'b0;

    terminal_key_sequence_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Random backpressure on the master side.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: mismatch in %s: got 0x%h, expected 0x%h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic key_event_t key_event(input logic [3:0] k);
        key_event_t ev;
        ev.key  = k;
        ev.chr  = 8'h00;
        ev.last = 1'b0;
        return ev;
    endfunction

    // Add one event to those of the current byte.
    function automatic void append_event(input key_event_t ev);
        byte_events = {byte_events, ev};
    endfunction

    // A byte seen with no sequence open: an Escape opens one, others map to keys.
    function automatic void decode_fresh(input logic [7:0] b);
        key_event_t ev;
        ev = key_event(KEY_CHAR);
        if (b == BYTE_ESC)
        begin
            pred_mode = MODE_ESC;
            return;
        end
        pred_mode = MODE_IDLE;
        if (b == BYTE_CR || b == BYTE_LF)
            ev.key = KEY_ENTER;
        else if (b == BYTE_DEL || b == BYTE_BS)
            ev.key = KEY_BKSP;
        else if (b == BYTE_TAB)
            ev.key = KEY_TAB;
        else
            ev.chr = b;
        append_event(ev);
    endfunction

    // Advance the tracked parser by one accepted byte and queue the key events it gives.
    function automatic void predict_keys(input logic [7:0] b, input logic eob);
        logic is_fin;
        is_fin = (b >= FINAL_LO) && (b <= FINAL_HI);
        byte_events.delete();
        case (pred_mode)
            MODE_ESC:
            begin
                if (b == BYTE_LBRK)
                    pred_mode = MODE_CSI;
                else
                begin
                    append_event(key_event(KEY_ESC));
                    decode_fresh(b);
                end
            end
            MODE_CSI:
            begin
                pred_mode = MODE_IDLE;
                case (b)
                    BYTE_UP:    append_event(key_event(KEY_UP));
                    BYTE_DOWN:  append_event(key_event(KEY_DOWN));
                    BYTE_RIGHT: append_event(key_event(KEY_RIGHT));
                    BYTE_LEFT:  append_event(key_event(KEY_LEFT));
                    BYTE_HOME:  append_event(key_event(KEY_HOME));
                    BYTE_END:   append_event(key_event(KEY_END));
                    BYTE_FIVE, BYTE_SIX:
                    begin
                        pred_pgdn = (b == BYTE_SIX);
                        pred_mode = MODE_DIG;
                    end
                    default:
                    begin
                        if (!is_fin)
                            pred_mode = MODE_SKIP;
                    end
                endcase
            end
            MODE_DIG:
            begin
                if (b == BYTE_TILDE)
                begin
                    append_event(key_event(pred_pgdn ? KEY_PGDN : KEY_PGUP));
                    pred_mode = MODE_IDLE;
                end
                else
                    pred_mode = is_fin ? MODE_IDLE : MODE_SKIP;
                pred_pgdn = 1'b0;
            end
            MODE_SKIP:
            begin
                if (is_fin)
                    pred_mode = MODE_IDLE;
            end
            default:
                decode_fresh(b);
        endcase

        // The end of a read buffer closes any open sequence; a lone Escape still counts.
        if (eob)
        begin
            if (pred_mode == MODE_ESC)
                append_event(key_event(KEY_ESC));
            pred_mode = MODE_IDLE;
            pred_pgdn = 1'b0;
        end

        if (byte_events.size() > 0)
            byte_events[byte_events.size() - 1].last = 1'b1;
        foreach (byte_events[i])
            expected_keys = {expected_keys, byte_events[i]};
    endfunction

    // Offer one byte on the slave side, with random idle cycles ahead of it.
    task automatic send_byte(input logic [7:0] b, input logic eob);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        do
            @(posedge clk);
        while (!s_tready);
        predict_keys(b, eob);
        bytes_sent++;
    endtask

    // Compare each key event leaving the master side with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        key_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_keys.size() == 0)
                report_mismatch("key event with none expected", m_tdata, 16'h0000);
            else
            begin
                want = expected_keys.pop_front();
                if (m_tdata[3:0] !== want.key)
                    report_mismatch("key_code", {12'h000, m_tdata[3:0]}, {12'h000, want.key});
                if (m_tdata[11:4] !== want.chr)
                    report_mismatch("char_value", {8'h00, m_tdata[11:4]}, {8'h00, want.chr});
                if (m_tdata[15:12] !== 4'h0)
                    report_mismatch("tdata padding", {12'h000, m_tdata[15:12]}, 16'h0000);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", {15'h0000, m_tlast}, {15'h0000, want.last});
            end
        end
    end

    // Plain bytes, including the extremes of the byte range.
    task automatic test_single_byte_keys();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(BYTE_CR, 1'b0);
        send_byte(BYTE_LF, 1'b0);
        send_byte(BYTE_DEL, 1'b0);
        send_byte(BYTE_BS, 1'b0);
        send_byte(BYTE_TAB, 1'b1);
    endtask

    // Recognized CSI sequences: an arrow, PageDown and PageUp.
    task automatic test_csi_keys();
        send_byte(BYTE_ESC, 1'b0);
        send_byte(BYTE_LBRK, 1'b0);
        send_byte(BYTE_UP, 1'b0);
        send_byte(BYTE_ESC, 1'b0);
        send_byte(BYTE_LBRK, 1'b0);
        send_byte(BYTE_SIX, 1'b0);
        send_byte(BYTE_TILDE, 1'b0);
        send_byte(BYTE_ESC, 1'b0);
        send_byte(BYTE_LBRK, 1'b0);
        send_byte(BYTE_FIVE, 1'b0);
        send_byte(BYTE_TILDE, 1'b0);
    endtask

    // A digit followed by a final byte other than a tilde ends the sequence silently.
    task automatic test_digit_without_tilde();
        send_byte(BYTE_ESC, 1'b0);
        send_byte(BYTE_LBRK, 1'b0);
        send_byte(BYTE_FIVE, 1'b0);
        send_byte(BYTE_LEFT, 1'b0);
    endtask

    // Escape followed by an ordinary byte, and two Escapes at a buffer end: two events each.
    task automatic test_escape_handling();
        send_byte(BYTE_ESC, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(BYTE_ESC, 1'b0);
        send_byte(BYTE_ESC, 1'b1);
    endtask

    // Sequences cut off by the end of a buffer: a partial CSI is dropped, a lone Escape is not.
    task automatic test_buffer_end();
        send_byte(BYTE_ESC, 1'b0);
        send_byte(BYTE_LBRK, 1'b1);
        send_byte(BYTE_ESC, 1'b1);
    endtask

    function automatic logic [7:0] pick_csi_final();
        case ($urandom_range(5))
            0: return BYTE_UP;
            1: return BYTE_DOWN;
            2: return BYTE_RIGHT;
            3: return BYTE_LEFT;
            4: return BYTE_HOME;
            default: return BYTE_END;
        endcase
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(5))
            0: return BYTE_CR;
            1: return BYTE_LF;
            2: return BYTE_DEL;
            3: return BYTE_BS;
            4: return BYTE_TAB;
            default: return BYTE_ESC;
        endcase
    endfunction

    // A byte that now and then closes a read buffer.
    task automatic send_rand(input logic [7:0] b);
        send_byte(b, $urandom_range(99) < 6);
    endtask

    // One random group: mostly complete sequences, some plain bytes, some broken ones.
    task automatic send_random_group();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 20)
        begin
            send_rand(BYTE_ESC);
            send_rand(BYTE_LBRK);
            send_rand(pick_csi_final());
        end
        else if (kind < 30)
        begin
            send_rand(BYTE_ESC);
            send_rand(BYTE_LBRK);
            send_rand($urandom_range(1) ? BYTE_SIX : BYTE_FIVE);
            send_rand(BYTE_TILDE);
        end
        else if (kind < 42)
        begin
            // Unknown CSI with parameter bytes, closed by a random final byte.
            send_rand(BYTE_ESC);
            send_rand(BYTE_LBRK);
            n = $urandom_range(3);
            repeat (n)
                send_rand(8'($urandom_range(8'h3F, 8'h20)));
            send_rand(8'($urandom_range(FINAL_HI, FINAL_LO)));
        end
        else if (kind < 52)
        begin
            send_rand(BYTE_ESC);
            send_rand(8'($urandom_range(255)));
        end
        else if (kind < 66)
            send_rand(8'($urandom_range(255)));
        else if (kind < 80)
            send_rand(pick_special());
        else if (kind < 90)
        begin
            // Sequence cut short by the end of a buffer.
            n = $urandom_range(2);
            send_byte(BYTE_ESC, n == 0);
            if (n >= 1)
                send_byte(BYTE_LBRK, n == 1);
            if (n == 2)
                send_byte($urandom_range(1) ? BYTE_SIX : BYTE_FIVE, 1'b1);
        end
        else
        begin
            // Escape followed by arbitrary noise.
            send_rand(BYTE_ESC);
            n = $urandom_range(4, 1);
            repeat (n)
                send_rand(8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
            send_random_group();
    endtask

    // Stimulus sequence and final verdict.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_byte_keys();
        test_csi_keys();
        test_digit_without_tilde();
        test_escape_handling();
        test_buffer_end();
        test_random_traffic(200);

        src_idle_pct   = 45;
        sink_stall_pct = 29;
        test_random_traffic(200);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_traffic(200);

        s_tvalid <= 1'b0;
        while (expected_keys.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("terminal_key_sequence_decoder_tb: PASS");
        else
            $display("terminal_key_sequence_decoder_tb: FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #400000;
        $display("terminal_key_sequence_decoder_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tkd_pkg.sv
rtl/core/tkd_front.sv
rtl/core/tkd_queue.sv
rtl/core/tkd_back.sv
rtl/core/terminal_key_sequence_decoder.sv
test/terminal_key_sequence_decoder_tb.sv
